[rtl/core/assert_macros.svh]
// assertion helper macros for the core rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define AST_CHK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// condition must never be seen outside reset
`define AST_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

[rtl/core/pucg_pkg.sv]
// shared types, widths and the factorial table for the cycle generator
// no dependencies
`default_nettype none

package pucg_pkg;

    localparam int SYM_W   = 4;
    localparam int COUNT_W = 4;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd4;
    localparam logic [COUNT_W-1:0] COUNT_MIN   = 4'd2;

    typedef logic [SYM_W-1:0]   t_symbol;
    typedef logic [COUNT_W-1:0] t_count;

    function automatic logic [31:0] factorial(input logic [COUNT_W-1:0] k);
        logic [31:0] f;
        case (k)
            4'd0:    f = 32'd1;
            4'd1:    f = 32'd1;
            4'd2:    f = 32'd2;
            4'd3:    f = 32'd6;
            4'd4:    f = 32'd24;
            4'd5:    f = 32'd120;
            4'd6:    f = 32'd720;
            4'd7:    f = 32'd5040;
            4'd8:    f = 32'd40320;
            4'd9:    f = 32'd362880;
            4'd10:   f = 32'd3628800;
            4'd11:   f = 32'd39916800;
            4'd12:   f = 32'd479001600;
            default: f = 32'd1;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

[rtl/core/pucg_ifs.sv]
// valid/ready channel interfaces: item input, result output, count write
// depends on pucg_pkg
`default_nettype none

interface pucg_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface pucg_out_if import pucg_pkg::*;;
    logic    valid;
    logic    ready;
    t_symbol symbol;
    logic    rotation_kind;
    logic    last;

    modport source (output valid, output symbol, output rotation_kind, output last,
                    input ready);
    modport sink (input valid, input symbol, input rotation_kind, input last,
                  output ready);
endinterface

interface pucg_cfg_if import pucg_pkg::*;;
    logic   valid;
    logic   ready;
    t_count symbol_count;

    modport source (output valid, output symbol_count, input ready);
    modport sink (input valid, input symbol_count, output ready);
endinterface

`default_nettype wire

[rtl/core/pucg_step.sv]
// one generator step: optional reinit, loopless bit step and permutation rotate
// depends on pucg_pkg
`default_nettype none

module pucg_step import pucg_pkg::*; #(
    parameter int MAX_SYMBOLS = 8,
    localparam int IW = $clog2(MAX_SYMBOLS + 2),
    localparam int OW = IW + 2
) (
    input  logic [IW-1:0]                          i_n,
    input  logic                                   i_clear,
    input  logic [MAX_SYMBOLS-1:0][SYM_W-1:0]      i_perm,
    input  logic [MAX_SYMBOLS+1:0][OW-1:0]         i_offsets,
    input  logic [MAX_SYMBOLS+1:0]                 i_dirs,
    input  logic [MAX_SYMBOLS+1:0][IW-1:0]         i_focus,
    output logic [MAX_SYMBOLS-1:0][SYM_W-1:0]      o_perm,
    output logic [MAX_SYMBOLS+1:0][OW-1:0]         o_offsets,
    output logic [MAX_SYMBOLS+1:0]                 o_dirs,
    output logic [MAX_SYMBOLS+1:0][IW-1:0]         o_focus,
    output t_symbol                                o_symbol,
    output logic                                   o_bit
);

    logic [MAX_SYMBOLS-1:0][SYM_W-1:0] c_perm;
    logic [MAX_SYMBOLS+1:0][OW-1:0]    c_off;
    logic [MAX_SYMBOLS+1:0]            c_dir;
    logic [MAX_SYMBOLS+1:0][IW-1:0]    c_foc;
    logic [IW-1:0]                     j;
    logic [IW-1:0]                     jn;
    logic [IW-1:0]                     len;
    logic signed [OW-1:0]              dj;
    logic signed [OW-1:0]              lim;
    logic signed [OW-1:0]              diff;
    logic signed [OW-1:0]              newoff;
    logic                              edge_hit;

    // current state, or the initial state when clearing
    always_comb begin
        for (int i = 0; i < MAX_SYMBOLS; i++) begin
            if (i_clear) begin
                c_perm[i] = (IW'(i) < i_n) ? SYM_W'(i_n - IW'(i)) : '0;
            end else begin
                c_perm[i] = i_perm[i];
            end
        end
        for (int i = 0; i < MAX_SYMBOLS + 2; i++) begin
            if (i_clear) begin
                c_off[i] = '0;
                c_dir[i] = 1'b1;
                c_foc[i] = (IW'(i) == i_n) ? i_n + IW'(1) : IW'(i);
            end else begin
                c_off[i] = i_offsets[i];
                c_dir[i] = i_dirs[i];
                c_foc[i] = i_focus[i];
            end
        end
    end

    // loopless bit generator
    always_comb begin
        j = (c_foc[1] > IW'(MAX_SYMBOLS + 1)) ? IW'(MAX_SYMBOLS + 1) : c_foc[1];
        jn = j + IW'(1);
        dj = c_dir[j] ? OW'(1) : '1;
        lim = $signed({2'b00, i_n}) - $signed({2'b00, j});
        diff = $signed(c_off[j]) - dj;
        edge_hit = (diff <= 0) || (diff >= lim);
        o_bit = (~j[0]) == edge_hit;
        newoff = $signed(c_off[j]) + dj;

        o_offsets = c_off;
        o_dirs = c_dir;
        o_focus = c_foc;
        o_focus[1] = IW'(1);
        o_offsets[j] = newoff;
        if ((newoff == '0 || newoff == lim) && (j <= IW'(MAX_SYMBOLS))) begin
            o_dirs[j] = ~c_dir[j];
            o_focus[j] = o_focus[jn];
            o_focus[jn] = jn;
        end
    end

    // rotate the first n entries of the permutation or its first n-1 entries
    always_comb begin
        len = o_bit ? i_n - IW'(1) : i_n;
        o_symbol = c_perm[0];
        for (int i = 0; i < MAX_SYMBOLS - 1; i++) begin
            if (IW'(i + 1) < len) begin
                o_perm[i] = c_perm[i + 1];
            end else if (IW'(i + 1) == len) begin
                o_perm[i] = c_perm[0];
            end else begin
                o_perm[i] = c_perm[i];
            end
        end
        o_perm[MAX_SYMBOLS-1] = (len == IW'(MAX_SYMBOLS)) ? c_perm[0]
                                                          : c_perm[MAX_SYMBOLS-1];
    end

endmodule

`default_nettype wire

[rtl/core/permutation_universal_cycle_generator_core.sv]
// top level of the permutation universal cycle generator
// depends on pucg_pkg, pucg_ifs, pucg_step and assert_macros.svh
//
//  channel   dir  fields                           transaction
//  i_item    in   restart                          one symbol request
//  o_result  out  symbol, rotation_kind, last      one symbol of the cycle
//  i_cfg     in   symbol_count                     count write, reinit
//
// one symbol per clock while the result is not stalled; the result is registered on request accept
// the state update (bit step plus rotate) is combinational logic in pucg_step
// sync active-low reset; count resets to 4, state is rebuilt on first request
// a stalled result holds; a new request is taken while it is being drained
`default_nettype none
`include "assert_macros.svh"

module permutation_universal_cycle_generator_core import pucg_pkg::*; #(
    parameter int MAX_SYMBOLS = 8
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    pucg_in_if.sink    i_item,
    pucg_out_if.source o_result,
    pucg_cfg_if.sink   i_cfg
);

    localparam int IW = $clog2(MAX_SYMBOLS + 2);
    localparam int OW = IW + 2;
    localparam int PW = ($clog2(factorial(COUNT_W'(MAX_SYMBOLS))) < 1) ? 1
                        : $clog2(factorial(COUNT_W'(MAX_SYMBOLS)));

    logic                              r_live;
    t_count                            r_count;
    logic                              r_reinit;
    logic                              r_valid;
    t_symbol                           r_symbol;
    logic                              r_rot;
    logic                              r_last;
    logic [PW-1:0]                     r_position;
    logic [MAX_SYMBOLS-1:0][SYM_W-1:0] r_perm;
    logic [MAX_SYMBOLS+1:0][OW-1:0]    r_offsets;
    logic [MAX_SYMBOLS+1:0]            r_dirs;
    logic [MAX_SYMBOLS+1:0][IW-1:0]    r_focus;

    logic [MAX_SYMBOLS-1:0][SYM_W-1:0] n_perm;
    logic [MAX_SYMBOLS+1:0][OW-1:0]    n_offsets;
    logic [MAX_SYMBOLS+1:0]            n_dirs;
    logic [MAX_SYMBOLS+1:0][IW-1:0]    n_focus;
    t_symbol                           n_symbol;
    logic                              n_rot;

    logic          w_in_acc;
    logic          w_cfg_acc;
    logic          w_clear;
    logic [IW-1:0] w_n;
    logic [PW-1:0] w_pos;
    logic          w_last;

    assign i_item.ready = r_live && (!r_valid || o_result.ready);
    assign i_cfg.ready = r_live;
    assign w_in_acc = i_item.valid && i_item.ready;
    assign w_cfg_acc = i_cfg.valid && i_cfg.ready;

    assign o_result.valid = r_valid;
    assign o_result.symbol = r_symbol;
    assign o_result.rotation_kind = r_rot;
    assign o_result.last = r_last;

    // effective symbol count, clamped to the supported range
    always_comb begin
        if (r_count < COUNT_MIN) begin
            w_n = IW'(COUNT_MIN);
        end else if (r_count > COUNT_W'(MAX_SYMBOLS)) begin
            w_n = IW'(MAX_SYMBOLS);
        end else begin
            w_n = IW'(r_count);
        end
    end

    assign w_clear = i_item.restart || r_reinit;
    assign w_pos = w_clear ? '0 : r_position;
    assign w_last = (32'(w_pos) == (factorial(COUNT_W'(w_n)) - 32'd1));

    pucg_step #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_step (
        .i_n       (w_n),
        .i_clear   (w_clear),
        .i_perm    (r_perm),
        .i_offsets (r_offsets),
        .i_dirs    (r_dirs),
        .i_focus   (r_focus),
        .o_perm    (n_perm),
        .o_offsets (n_offsets),
        .o_dirs    (n_dirs),
        .o_focus   (n_focus),
        .o_symbol  (n_symbol),
        .o_bit     (n_rot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
            r_count <= COUNT_RESET;
            r_reinit <= 1'b1;
            r_valid <= 1'b0;
        end else begin
            r_live <= 1'b1;
            if (w_in_acc) begin
                r_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_valid <= 1'b0;
            end
            if (w_cfg_acc) begin
                r_count <= i_cfg.symbol_count;
                r_reinit <= 1'b1;
            end else if (w_in_acc) begin
                r_reinit <= w_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_symbol <= n_symbol;
            r_rot <= n_rot;
            r_last <= w_last;
            r_position <= w_pos + PW'(1);
            r_perm <= n_perm;
            r_offsets <= n_offsets;
            r_dirs <= n_dirs;
            r_focus <= n_focus;
        end
    end

    `AST_NEVER(a_sym_zero, i_clk, i_rst_n, r_valid && (r_symbol == '0))
    `AST_CHK(a_wrap_reinit, i_clk, i_rst_n, (w_in_acc && w_last) |=> r_reinit)
    `AST_CHK(a_pos_range, i_clk, i_rst_n, !r_reinit |-> (32'(r_position) < factorial(COUNT_W'(w_n))))

endmodule

`default_nettype wire

[test/tb_permutation_universal_cycle_generator_core.sv]
// self-checking testbench for permutation_universal_cycle_generator_core: directed table,
// then random requests and count writes under several sender and receiver idling phases
// depends on pucg_pkg, pucg_ifs and the core rtl
module tb_permutation_universal_cycle_generator_core;
    import pucg_pkg::*;

    localparam int MAX_SYMBOLS = 8;
    localparam int PLAN_LEN    = 32;
    localparam int SEGMENTS    = 4;
    localparam int SEG_ITEMS   = 125;

    typedef enum logic [0:0] {ROW_ITEM, ROW_COUNT} row_op_e;

    typedef struct packed {
        t_symbol symbol;
        logic    rotation_kind;
        logic    last;
    } result_t;

    typedef struct packed {
        bit      typed;
        result_t want;
    } note_t;

    typedef struct packed {
        row_op_e op;
        t_count  value;
        bit      typed;
        t_symbol symbol;
        logic    rotation_kind;
        logic    last;
    } row_t;

    bit   clk        = 1'b0;
    logic rst_n      = 1'b0;
    logic sink_ready = 1'b0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;

    int idle_plan  [4] = '{0, 79, 0, 19};
    int stall_plan [4] = '{0, 0, 79, 19};

    // cycle generator mirror
    t_count  cur_count;
    t_symbol perm   [MAX_SYMBOLS];
    int      offs   [MAX_SYMBOLS+2];
    bit      dir_up [MAX_SYMBOLS+2];
    int      foc    [MAX_SYMBOLS+2];
    int      cycle_pos;

    result_t pending_symbols [$];
    note_t   item_notes      [$];

    row_t stim_plan [PLAN_LEN] = '{
        '{ROW_ITEM,  4'd0,  1'b1, 4'd4, 1'b0, 1'b0},
        '{ROW_ITEM,  4'd0,  1'b0, 4'd0, 1'b0, 1'b0},
        '{ROW_ITEM,  4'd1,  1'b1, 4'd4, 1'b0, 1'b0},
        '{ROW_COUNT, 4'd2,  1'b0, 4'd0, 1'b0, 1'b0},
        '{ROW_ITEM,  4'd0,  1'b1, 4'd2, 1'b0, 1'b0},
        '{ROW_ITEM,  4'd0,  1'b1, 4'd1, 1'b0, 1'b1},
        '{ROW_ITEM,  4'd0,  1'b1, 4'd2, 1'b0, 1'b0},
        '{ROW_ITEM,  4'd1,  1'b1, 4'd2, 1'b0, 1'b0},
        '{ROW_COUNT, 4'd0,  1'b0, 4'd0, 1'b0, 1'b0},
        '{ROW_ITEM,  4'd0,  1'b1, 4'd2, 1'b0, 1'b0},
        '{ROW_ITEM,  4'd0,  1'b1, 4'd1, 1'b0, 1'b1},
        '{ROW_COUNT, 4'd1,  1'b0, 4'd0, 1'b0, 1'b0},
        '{ROW_ITEM,  4'd0,  1'b1, 4'd2, 1'b0, 1'b0},
        '{ROW_COUNT, 4'd15, 1'b0, 4'd0, 1'b0, 1'b0},
        '{ROW_ITEM,  4'd0,  1'b1, 4'd8, 1'b0, 1'b0},
        '{ROW_ITEM,  4'd0,  1'b0, 4'd0, 1'b0, 1'b0},
        '{ROW_ITEM,  4'd0,  1'b0, 4'd0, 1'b0, 1'b0},
        '{ROW_ITEM,  4'd0,  1'b0, 4'd0, 1'b0, 1'b0},
        '{ROW_ITEM,  4'd1,  1'b1, 4'd8, 1'b0, 1'b0},
        '{ROW_COUNT, 4'd8,  1'b0, 4'd0, 1'b0, 1'b0},
        '{ROW_ITEM,  4'd0,  1'b1, 4'd8, 1'b0, 1'b0},
        '{ROW_ITEM,  4'd0,  1'b0, 4'd0, 1'b0, 1'b0},
        '{ROW_COUNT, 4'd3,  1'b0, 4'd0, 1'b0, 1'b0},
        '{ROW_ITEM,  4'd0,  1'b0, 4'd0, 1'b0, 1'b0},
        '{ROW_ITEM,  4'd0,  1'b0, 4'd0, 1'b0, 1'b0},
        '{ROW_ITEM,  4'd0,  1'b0, 4'd0, 1'b0, 1'b0},
        '{ROW_ITEM,  4'd0,  1'b0, 4'd0, 1'b0, 1'b0},
        '{ROW_ITEM,  4'd0,  1'b0, 4'd0, 1'b0, 1'b0},
        '{ROW_ITEM,  4'd0,  1'b0, 4'd0, 1'b0, 1'b0},
        '{ROW_ITEM,  4'd0,  1'b0, 4'd0, 1'b0, 1'b0},
        '{ROW_COUNT, 4'd9,  1'b0, 4'd0, 1'b0, 1'b0},
        '{ROW_ITEM,  4'd0,  1'b1, 4'd8, 1'b0, 1'b0}
    };

    pucg_in_if  item_if ();
    pucg_out_if res_if ();
    pucg_cfg_if cfg_if ();

    assign res_if.ready = sink_ready;

    permutation_universal_cycle_generator_core #(
        .MAX_SYMBOLS(MAX_SYMBOLS)
    ) u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_item  (item_if),
        .o_result(res_if),
        .i_cfg   (cfg_if)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    initial begin
        #4000000;
        $display("** permutation_universal_cycle_generator_core: FAILED **");
        $finish;
    end

    function automatic int active_n();
        if (cur_count < 2) return 2;
        if (cur_count > MAX_SYMBOLS) return MAX_SYMBOLS;
        return int'(cur_count);
    endfunction

    function automatic void reload_cycle();
        int n;
        n = active_n();
        for (int i = 0; i < MAX_SYMBOLS; i++) begin
            perm[i] = (i < n) ? t_symbol'(n - i) : '0;
        end
        for (int i = 0; i < MAX_SYMBOLS + 2; i++) begin
            offs[i]   = 0;
            dir_up[i] = 1'b1;
            foc[i]    = i;
        end
        foc[n]    = n + 1;
        cycle_pos = 0;
    endfunction

    function automatic result_t next_symbol(input bit restart);
        int      n;
        int      j;
        int      dj;
        int      lim;
        int      diff;
        int      span;
        int      fact;
        bit      even;
        bit      at_end;
        t_symbol head;
        result_t r;
        n = active_n();
        if (restart) reload_cycle();
        r.symbol = perm[0];

        // loopless step for the rotation bit
        j = foc[1];
        if (j > MAX_SYMBOLS + 1) j = MAX_SYMBOLS + 1;
        foc[1] = 1;
        dj     = dir_up[j] ? 1 : -1;
        lim    = n - j;
        diff   = offs[j] - dj;
        even   = (j % 2) == 0;
        at_end = (diff <= 0) || (diff >= lim);
        r.rotation_kind = (even != at_end) ? 1'b0 : 1'b1;
        offs[j] += dj;
        if ((offs[j] == 0 || offs[j] == lim) && j + 1 < MAX_SYMBOLS + 2) begin
            dir_up[j]  = !dir_up[j];
            foc[j]     = foc[j+1];
            foc[j+1]   = j + 1;
        end

        span = r.rotation_kind ? n - 1 : n;
        if (span >= 2) begin
            head = perm[0];
            for (int i = 0; i + 1 < span; i++) perm[i] = perm[i+1];
            perm[span-1] = head;
        end

        fact = 1;
        for (int k = 2; k <= n; k++) fact *= k;
        r.last = (cycle_pos + 1 >= fact);
        if (r.last) reload_cycle();
        else cycle_pos++;
        return r;
    endfunction

    // receiver
    always @(posedge clk) begin
        sink_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // checker and mirror update
    always @(posedge clk) begin
        result_t want;
        result_t got;
        note_t   note;
        if (!rst_n) begin
            cur_count = COUNT_RESET;
            reload_cycle();
        end else begin
            if (res_if.valid && sink_ready) begin
                if (pending_symbols.size() == 0) begin
                    $error("unexpected transaction: symbol %0d", res_if.symbol);
                    error_count++;
                end else begin
                    want = pending_symbols.pop_front();
                    if (res_if.symbol !== want.symbol) begin
                        $error("symbol: expected %0d, got %0d", want.symbol, res_if.symbol);
                        error_count++;
                    end
                    if (res_if.rotation_kind !== want.rotation_kind) begin
                        $error("rotation_kind: expected %0d, got %0d",
                               want.rotation_kind, res_if.rotation_kind);
                        error_count++;
                    end
                    if (res_if.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, res_if.last);
                        error_count++;
                    end
                end
            end
            if (cfg_if.valid && cfg_if.ready) begin
                cur_count = cfg_if.symbol_count;
                reload_cycle();
            end
            if (item_if.valid && item_if.ready) begin
                got  = next_symbol(item_if.restart);
                note = item_notes.pop_front();
                pending_symbols.push_back(note.typed ? note.want : got);
            end
        end
    end

    task automatic send_request(input bit restart, input bit typed, input result_t want);
        int gap;
        if ($urandom_range(99) < send_idle_pct) begin
            item_if.valid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge clk);
        end
        item_notes.push_back('{typed, want});
        item_if.valid   <= 1'b1;
        item_if.restart <= restart;
        do @(posedge clk); while (!item_if.ready);
    endtask

    task automatic write_count(input t_count value);
        item_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_symbols.size() != 0) @(posedge clk);
        cfg_if.valid        <= 1'b1;
        cfg_if.symbol_count <= value;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    initial begin
        t_count cnt;
        item_if.valid       <= 1'b0;
        item_if.restart     <= 1'b0;
        cfg_if.valid        <= 1'b0;
        cfg_if.symbol_count <= COUNT_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_plan[r]) begin
            if (stim_plan[r].op == ROW_COUNT) begin
                write_count(stim_plan[r].value);
            end else begin
                send_request(stim_plan[r].value[0], stim_plan[r].typed,
                             '{stim_plan[r].symbol, stim_plan[r].rotation_kind,
                               stim_plan[r].last});
            end
        end

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = idle_plan[ph];
            recv_stall_pct = stall_plan[ph];
            for (int s = 0; s < SEGMENTS; s++) begin
                // mostly short cycles so that wraps are seen often
                if ($urandom_range(99) < 70) cnt = t_count'($urandom_range(2, 5));
                else cnt = t_count'($urandom_range(0, 15));
                write_count(cnt);
                for (int i = 0; i < SEG_ITEMS; i++) begin
                    send_request($urandom_range(99) < 3, 1'b0, '0);
                end
            end
        end

        item_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_symbols.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (error_count == 0 && pending_symbols.size() == 0) begin
            $display("** permutation_universal_cycle_generator_core: PASSED **");
        end else begin
            $display("** permutation_universal_cycle_generator_core: FAILED **");
        end
        $finish;
    end

endmodule

[permutation_universal_cycle_generator_core.f]
+incdir+rtl/core
rtl/core/pucg_pkg.sv
rtl/core/pucg_ifs.sv
rtl/core/pucg_step.sv
rtl/core/permutation_universal_cycle_generator_core.sv
test/tb_permutation_universal_cycle_generator_core.sv
